@@ src/error_function_approximation_core_macros.svh @@
// ----------------------------------------------------------------------------
// erf core assertion macros
// shared concurrent assertion forms for the erf core checker
// ----------------------------------------------------------------------------
`ifndef ERROR_FUNCTION_APPROXIMATION_CORE_MACROS_SVH
`define ERROR_FUNCTION_APPROXIMATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ERFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ERFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/erfa_pkg.sv @@
// ----------------------------------------------------------------------------
// erfa_pkg
// constants and stage boundary types of the erf core
// ----------------------------------------------------------------------------
package erfa_pkg;

  // 0.147 in Q0.32
  localparam logic [29:0] ALPHA_Q32 = 30'd631360193;
  // (4/pi - 1) in Q0.32, doubled: first partial remainder of the ratio divide
  localparam logic [36:0] DIV_INIT  = 37'd2347109818;
  localparam logic [55:0] LN2_Q56   = 56'hB17217F7D1CF7A;
  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;

  localparam int DIV_STEPS  = 31;
  localparam int RED_STEPS  = 8;
  localparam int EXP_TERMS  = 20;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic        neg;
    logic [62:0] t;
  } red_in_t;

  typedef struct packed {
    logic        neg;
    logic [7:0]  k;
    logic [61:0] r;
  } ser_in_t;

  typedef struct packed {
    logic        neg;
    logic [7:0]  k;
    logic [63:0] em;
  } sqr_in_t;

endpackage

@@ src/erfa_front.sv @@
// ----------------------------------------------------------------------------
// erfa_front
// |x| squared, alpha term, restoring ratio divide and t = x^2 * ratio
// ----------------------------------------------------------------------------
module erfa_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    vld_in,
  input  logic [31:0]             x,
  output logic                    vld_out,
  output erfa_pkg::red_in_t       dat_out
);

  localparam int NS = erfa_pkg::DIV_STEPS + 4;

  typedef struct packed {
    logic        neg;
    logic [62:0] xsq;   // holds t after the last stage
    logic [36:0] den;
    logic [36:0] rem;
    logic [30:0] q;
    logic [61:0] pa;
    logic [62:0] pb;
  } fr_t;

  fr_t         d [1:NS];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], vld_in};
    end
  end

  assign vld_out = vld[NS-1];

  // stage 1: magnitude and square
  logic [31:0] mag;
  logic [63:0] sq;
  fr_t         nx1;

  assign mag = x[31] ? (~x + 32'd1) : x;
  assign sq  = {32'd0, mag} * {32'd0, mag};

  always_comb begin
    nx1     = '0;
    nx1.neg = x[31];
    nx1.xsq = sq[62:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[1] <= nx1;
    end
  end

  // stage 2: denominator 1 + alpha x^2
  logic [68:0] az;
  fr_t         nx2;

  assign az = {30'd0, d[1].xsq[62:24]} * {39'd0, erfa_pkg::ALPHA_Q32};

  always_comb begin
    nx2     = d[1];
    nx2.den = 37'h1_0000_0000 + az[68:32];
    nx2.rem = erfa_pkg::DIV_INIT;
    nx2.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[2] <= nx2;
    end
  end

  // one quotient bit per stage
  for (genvar J = 0; J < erfa_pkg::DIV_STEPS; J++) begin : g_div
    localparam int S = J + 3;
    logic [37:0] r2;
    logic [37:0] df;
    fr_t         nx;

    assign r2 = {d[S-1].rem, 1'b0};
    assign df = r2 - {1'b0, d[S-1].den};

    always_comb begin
      nx = d[S-1];
      if (r2 >= {1'b0, d[S-1].den}) begin
        nx.rem = df[36:0];
        nx.q   = {d[S-1].q[29:0], 1'b1};
      end else begin
        nx.rem = r2[36:0];
        nx.q   = {d[S-1].q[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d[S] <= nx;
      end
    end
  end

  // partial products of x^2 * (ratio - 1)
  localparam int SP = erfa_pkg::DIV_STEPS + 3;
  fr_t nxp;

  always_comb begin
    nxp    = d[SP-1];
    nxp.pa = {31'd0, d[SP-1].xsq[62:32]} * {31'd0, d[SP-1].q};
    nxp.pb = {31'd0, d[SP-1].xsq[31:0]} * {32'd0, d[SP-1].q};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[SP] <= nxp;
    end
  end

  // t = x^2 + x^2 * (ratio - 1)
  fr_t nxt;

  always_comb begin
    nxt     = d[NS-1];
    nxt.xsq = d[NS-1].xsq + {1'b0, d[NS-1].pa} + {32'd0, d[NS-1].pb[62:32]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[NS] <= nxt;
    end
  end

  assign dat_out.neg = d[NS].neg;
  assign dat_out.t   = d[NS].xsq;

endmodule

@@ src/erfa_reduce.sv @@
// ----------------------------------------------------------------------------
// erfa_reduce
// range reduction t = k ln2 + r by long division with the constant ln2
// ----------------------------------------------------------------------------
module erfa_reduce (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    vld_in,
  input  erfa_pkg::red_in_t       dat_in,
  output logic                    vld_out,
  output erfa_pkg::ser_in_t       dat_out
);

  localparam int NS = erfa_pkg::RED_STEPS;

  typedef struct packed {
    logic        neg;
    logic [7:0]  k;
    logic [62:0] rem;
  } rd_t;

  rd_t           d [1:NS];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], vld_in};
    end
  end

  assign vld_out = vld[NS-1];

  for (genvar J = 0; J < NS; J++) begin : g_step
    localparam int          B    = NS - 1 - J;
    localparam logic [62:0] SUBV = {7'd0, erfa_pkg::LN2_Q56} << B;
    rd_t src;
    rd_t nx;

    if (J == 0) begin : g_first
      assign src = {dat_in.neg, 8'd0, dat_in.t};
    end else begin : g_next
      assign src = d[J];
    end

    always_comb begin
      nx = src;
      if (src.rem >= SUBV) begin
        nx.rem  = src.rem - SUBV;
        nx.k[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d[J+1] <= nx;
      end
    end
  end

  // remainder below ln2, moved to Q0.62
  assign dat_out.neg = d[NS].neg;
  assign dat_out.k   = d[NS].k;
  assign dat_out.r   = {d[NS].rem[55:0], 6'd0};

endmodule

@@ src/erfa_series.sv @@
// ----------------------------------------------------------------------------
// erfa_series
// alternating taylor sum of 1 - exp(-r) in Q2.62, five stages for each term after r
// ----------------------------------------------------------------------------
module erfa_series (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    vld_in,
  input  erfa_pkg::ser_in_t       dat_in,
  output logic                    vld_out,
  output erfa_pkg::sqr_in_t       dat_out
);

  localparam int NT = erfa_pkg::EXP_TERMS - 1;
  localparam int NS = 5 * NT;

  typedef struct packed {
    logic        neg;
    logic [7:0]  k;
    logic [61:0] r;
    logic [63:0] em;
    logic [61:0] term;
    logic [61:0] q;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } sr_t;

  sr_t           d [1:NS];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], vld_in};
    end
  end

  assign vld_out = vld[NS-1];

  for (genvar I = 0; I < NT; I++) begin : g_term
    localparam int          N      = I + 2;
    localparam int          BASE   = 5 * I;
    localparam logic [64:0] TWO64  = {1'b1, 64'd0};
    localparam logic [64:0] RQ     = TWO64 / N;
    localparam logic [63:0] RECIP  = RQ[63:0];
    localparam logic [66:0] NV     = 67'(N);

    sr_t          src;
    sr_t          nxa;
    sr_t          nxb;
    sr_t          nxc;
    sr_t          nxd;
    sr_t          nxe;
    logic [127:0] prb;
    logic [127:0] prd;
    logic [66:0]  qn;
    logic [66:0]  rm;
    logic [61:0]  qc;

    if (I == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.neg  = dat_in.neg;
        src.k    = dat_in.k;
        src.r    = dat_in.r;
        src.em   = {2'd0, dat_in.r};
        src.term = dat_in.r;
      end
    end else begin : g_next
      assign src = d[BASE];
    end

    // term * r partial products
    always_comb begin
      nxa     = src;
      nxa.p00 = {32'd0, src.term[31:0]}  * {32'd0, src.r[31:0]};
      nxa.p01 = {32'd0, src.term[31:0]}  * {34'd0, src.r[61:32]};
      nxa.p10 = {34'd0, src.term[61:32]} * {32'd0, src.r[31:0]};
      nxa.p11 = {34'd0, src.term[61:32]} * {34'd0, src.r[61:32]};
    end

    // product >> 62
    assign prb = {64'd0, d[BASE+1].p00} + {32'd0, d[BASE+1].p01, 32'd0}
               + {32'd0, d[BASE+1].p10, 32'd0} + {d[BASE+1].p11, 64'd0};

    always_comb begin
      nxb      = d[BASE+1];
      nxb.term = prb[123:62];
    end

    // product * reciprocal of n, partial products
    always_comb begin
      nxc     = d[BASE+2];
      nxc.p00 = {32'd0, d[BASE+2].term[31:0]}  * {32'd0, RECIP[31:0]};
      nxc.p01 = {32'd0, d[BASE+2].term[31:0]}  * {32'd0, RECIP[63:32]};
      nxc.p10 = {34'd0, d[BASE+2].term[61:32]} * {32'd0, RECIP[31:0]};
      nxc.p11 = {34'd0, d[BASE+2].term[61:32]} * {32'd0, RECIP[63:32]};
    end

    // quotient estimate, low by at most one
    assign prd = {64'd0, d[BASE+3].p00} + {32'd0, d[BASE+3].p01, 32'd0}
               + {32'd0, d[BASE+3].p10, 32'd0} + {d[BASE+3].p11, 64'd0};

    always_comb begin
      nxd   = d[BASE+3];
      nxd.q = prd[125:64];
    end

    // correction and accumulation
    assign qn = {5'd0, d[BASE+4].q} * NV;
    assign rm = {5'd0, d[BASE+4].term} - qn;
    assign qc = (rm >= NV) ? (d[BASE+4].q + 62'd1) : d[BASE+4].q;

    always_comb begin
      nxe      = d[BASE+4];
      nxe.term = qc;
      if (N % 2 == 0) begin
        nxe.em = d[BASE+4].em - {2'd0, qc};
      end else begin
        nxe.em = d[BASE+4].em + {2'd0, qc};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d[BASE+1] <= nxa;
        d[BASE+2] <= nxb;
        d[BASE+3] <= nxc;
        d[BASE+4] <= nxd;
        d[BASE+5] <= nxe;
      end
    end
  end

  assign dat_out.neg = d[NS].neg;
  assign dat_out.k   = d[NS].k;
  assign dat_out.em  = d[NS].em;

endmodule

@@ src/erfa_sqrt.sv @@
// ----------------------------------------------------------------------------
// erfa_sqrt
// scales exp(-r) by 2^-k into 1 - exp(-t), bitwise integer square root and sign
// ----------------------------------------------------------------------------
module erfa_sqrt #(
  parameter int FRAC_BITS_OUT = 30
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    vld_in,
  input  erfa_pkg::sqr_in_t       dat_in,
  output logic                    vld_out,
  output logic [31:0]             erf
);

  localparam int NS = erfa_pkg::SQRT_STEPS + 2;

  typedef struct packed {
    logic        neg;
    logic [62:0] v;
    logic [62:0] res;
    logic [31:0] erf;
  } sq_t;

  sq_t           d [1:NS];
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], vld_in};
    end
  end

  assign vld_out = vld[NS-1];

  // 1 - exp(-t) from 1 - exp(-r) and k
  logic [63:0] om;
  logic [63:0] vs;
  sq_t         nx1;

  always_comb begin
    if (dat_in.k == 8'd0) begin
      om = dat_in.em;
    end else if (dat_in.k >= 8'd63) begin
      om = erfa_pkg::ONE_Q62;
    end else begin
      om = erfa_pkg::ONE_Q62 - ((erfa_pkg::ONE_Q62 - dat_in.em) >> dat_in.k);
    end
  end

  if (FRAC_BITS_OUT <= 31) begin : g_narrow
    localparam int SH = 62 - 2 * FRAC_BITS_OUT;
    assign vs = om >> SH;
  end else begin : g_wide
    assign vs = om;
  end

  always_comb begin
    nx1     = '0;
    nx1.neg = dat_in.neg;
    nx1.v   = vs[62:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[1] <= nx1;
    end
  end

  for (genvar J = 0; J < erfa_pkg::SQRT_STEPS; J++) begin : g_root
    localparam logic [62:0] BITV = 63'd1 << (62 - 2 * J);
    logic [63:0] sm;
    sq_t         nx;

    assign sm = {1'b0, d[J+1].res} + {1'b0, BITV};

    always_comb begin
      nx = d[J+1];
      if ({1'b0, d[J+1].v} >= sm) begin
        nx.v   = d[J+1].v - sm[62:0];
        nx.res = (d[J+1].res >> 1) + BITV;
      end else begin
        nx.res = d[J+1].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d[J+2] <= nx;
      end
    end
  end

  // output scaling and sign
  logic [63:0] mag;
  logic [63:0] sgn;
  sq_t         nxo;

  if (FRAC_BITS_OUT <= 31) begin : g_mag_narrow
    assign mag = {1'b0, d[NS-1].res};
  end else begin : g_mag_wide
    assign mag = {1'b0, d[NS-1].res} << (FRAC_BITS_OUT - 31);
  end

  assign sgn = d[NS-1].neg ? (~mag + 64'd1) : mag;

  always_comb begin
    nxo     = d[NS-1];
    nxo.erf = sgn[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[NS] <= nxo;
    end
  end

  assign erf = d[NS].erf;

endmodule

@@ src/error_function_approximation_core.sv @@
// ----------------------------------------------------------------------------
// error_function_approximation_core
// streaming erf(x) by the winitzki form, Q3.28 in, signed fixed point out
// ----------------------------------------------------------------------------
// The core takes one sample x (signed Q3.28) per clock while x_stall is
// low and returns one erf(x) per sample, in order, with FRAC_BITS_OUT
// fraction bits (Q1.30 by default). A sample passes through 35 stages for
// x^2 and the restoring divide of the rational factor (one quotient bit a
// stage), 8 for the ln2 range reduction, 95 for the 20-term exp series
// (five stages for each term after r: two for the product, two for the
// reciprocal divide by n, one for the correction), 34 for scaling, the
// 32-step square root and the output sign, and one output register.
// Throughput is one transaction per clock while x_stall is low.
// The whole pipeline moves together; a two-entry output buffer (output
// register plus skid register) takes the back-pressure, so x_stall is a
// register and rises only after a result has been held by erf_stall.
// Large |x| saturates to plus or minus one; for FRAC_BITS_OUT above 30
// that value wraps in the 32-bit result field.
// ----------------------------------------------------------------------------
module error_function_approximation_core #(
  parameter int FRAC_BITS_OUT = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               x_valid,
  output logic               x_stall,
  input  logic signed [31:0] x_value,
  output logic               erf_valid,
  input  logic               erf_stall,
  output logic signed [31:0] erf_value
);

  // pipeline advance: only the full skid register holds the pipeline
  logic adv;

  logic              fr_vld;
  erfa_pkg::red_in_t fr_dat;
  logic              rd_vld;
  erfa_pkg::ser_in_t rd_dat;
  logic              sr_vld;
  erfa_pkg::sqr_in_t sr_dat;
  logic              sq_vld;
  logic [31:0]       sq_erf;

  // output register and skid register
  logic        out_v;
  logic [31:0] out_d;
  logic        skid_v;
  logic [31:0] skid_d;
  logic        take;

  assign adv     = ~skid_v;
  assign x_stall = skid_v;

  // x^2, rational factor and t
  erfa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (x_valid),
    .x       (x_value),
    .vld_out (fr_vld),
    .dat_out (fr_dat)
  );

  // t = k ln2 + r
  erfa_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (fr_vld),
    .dat_in  (fr_dat),
    .vld_out (rd_vld),
    .dat_out (rd_dat)
  );

  // 1 - exp(-r)
  erfa_series u_series (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (rd_vld),
    .dat_in  (rd_dat),
    .vld_out (sr_vld),
    .dat_out (sr_dat)
  );

  // scale, square root, sign
  erfa_sqrt #(
    .FRAC_BITS_OUT (FRAC_BITS_OUT)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (sr_vld),
    .dat_in  (sr_dat),
    .vld_out (sq_vld),
    .erf     (sq_erf)
  );

  assign take = out_v & ~erf_stall;

  // a result leaving the pipeline goes to the output register when it is
  // free or being taken, otherwise into the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (sq_vld) begin
      if (!out_v || take) begin
        out_d <= sq_erf;
        out_v <= 1'b1;
      end else begin
        skid_d <= sq_erf;
        skid_v <= 1'b1;
      end
    end else if (take) begin
      out_v <= 1'b0;
    end
  end

  assign erf_valid = out_v;
  assign erf_value = out_d;

endmodule

@@ src/erfa_checker.sv @@
// ----------------------------------------------------------------------------
// erfa_checker
// port-level checks of the erf core, bound to the top level
// ----------------------------------------------------------------------------
`include "error_function_approximation_core_macros.svh"

module erfa_checker #(
  parameter int FRAC_BITS_OUT = 30
) (
  input logic        clk,
  input logic        rst,
  input logic        x_valid,
  input logic        x_stall,
  input logic [31:0] x_value,
  input logic        erf_valid,
  input logic        erf_stall,
  input logic [31:0] erf_value
);

  localparam logic [31:0] ONE_OUT = 32'd1 << ((FRAC_BITS_OUT <= 30) ? FRAC_BITS_OUT : 30);
  localparam logic [31:0] NEG_ONE = ~ONE_OUT + 32'd1;

  logic in_range;

  assign in_range = (FRAC_BITS_OUT > 30) || !erf_value[31] && (erf_value <= ONE_OUT)
                    || erf_value[31] && (erf_value >= NEG_ONE);

  // stalled input transaction holds
  `ERFA_ASSERT_NEXT(a_in_hold, x_valid && x_stall, x_valid && $stable(x_value), "stalled x changed")

  // stalled result transaction holds
  `ERFA_ASSERT_NEXT(a_out_hold, erf_valid && erf_stall, erf_valid && $stable(erf_value), "erf result changed while stalled")

  // input back-pressure only with a result waiting at the output
  `ERFA_ASSERT_NOW(a_stall_needs_out, x_stall, erf_valid, "x_stall without a pending result")

  // input back-pressure starts only after a stalled result
  `ERFA_ASSERT_NOW(a_stall_cause, $rose(x_stall), $past(erf_valid && erf_stall), "x_stall rose without output stall")

  // result magnitude never exceeds one, checked for FRAC_BITS_OUT up to 30
  `ERFA_ASSERT_NOW(a_range, erf_valid, in_range, "erf result beyond plus or minus one")

endmodule

bind error_function_approximation_core erfa_checker #(
  .FRAC_BITS_OUT (FRAC_BITS_OUT)
) u_erfa_checker (
  .clk       (clk),
  .rst       (rst),
  .x_valid   (x_valid),
  .x_stall   (x_stall),
  .x_value   (x_value),
  .erf_valid (erf_valid),
  .erf_stall (erf_stall),
  .erf_value (erf_value)
);
